// File: rtl/cdq_pkg.sv
package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int DEPTH_DEF = 16;
    localparam int CAP_RESET = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_BACK  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

// File: rtl/circular_deque.sv
// Results are registered: a push, a refused operation or a pop of the last element goes to
// the output register when accepted; a pop that leaves elements behind reads its slot in
// ST_READ first. Throughput: one push per cycle while o_stall is low; a pop keeps o_stall
// high through its slot read on the single read port, so no new operation is taken meanwhile.
// Reset (synchronous, active low): deque empty, indices zero, capacity 16. The slot memory
// is not cleared; no slot is ever read before a push has written it.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // capacity register
    input  logic                                i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]           i_cfg_data,
    // operation channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [cdq_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [cdq_pkg::DATA_W-1:0]   i_data_in,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [cdq_pkg::ST_W-1:0]            o_status,
    output logic [cdq_pkg::CAP_W-1:0]           o_occupancy,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_front_value,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_back_value
);

    localparam int CAP_W = cdq_pkg::CAP_W;
    localparam int DW    = cdq_pkg::DATA_W;
    localparam int IDX_W = $clog2(DEPTH);
    // compare width wide enough for both an index and a capacity, plus one
    localparam int CW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

    // Index step with wrap inside the slots in use.
    function automatic logic [IDX_W-1:0] f_step_fwd(input logic [IDX_W-1:0] idx,
                                                    input logic [CAP_W-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= CW'(cap)) ? '0 : IDX_W'(inc);
    endfunction

    function automatic logic [IDX_W-1:0] f_step_back(input logic [IDX_W-1:0] idx,
                                                     input logic [CAP_W-1:0] cap);
        logic [CW-1:0] dec;
        logic [CW-1:0] top;
        dec = CW'(idx) - CW'(1);
        top = CW'(cap) - CW'(1);
        return (idx == '0 || CW'(idx) >= CW'(cap)) ? IDX_W'(top) : IDX_W'(dec);
    endfunction

    // Slot memory: one write port, one registered read port.
    logic signed [DW-1:0] r_slots [DEPTH];
    logic signed [DW-1:0] r_rd_data;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slots[mem_wa] <= i_data_in;
        end
        if (mem_re) begin
            r_rd_data <= r_slots[mem_ra];
        end
    end

    // Control and mirror state
    cdq_pkg::t_state      r_state,     n_state;
    logic [IDX_W-1:0]     r_head,      n_head;
    logic [IDX_W-1:0]     r_tail,      n_tail;
    logic                 r_empty,     n_empty;
    logic [CAP_W-1:0]     r_count,     n_count;
    logic [CAP_W-1:0]     r_cap,       n_cap;
    logic signed [DW-1:0] r_front,     n_front;   // copy of slot at head
    logic signed [DW-1:0] r_back,      n_back;    // copy of slot at tail
    logic                 r_rd_front,  n_rd_front;

    // Output register
    logic                              r_out_valid,  n_out_valid;
    logic [cdq_pkg::ST_W-1:0]          r_out_status, n_out_status;
    logic [CAP_W-1:0]                  r_out_count,  n_out_count;
    logic signed [DW-1:0]              r_out_front,  n_out_front;
    logic signed [DW-1:0]              r_out_back,   n_out_back;

    logic                 in_acc;
    logic                 emit;
    cdq_pkg::t_status     status;
    logic [CAP_W-1:0]     cap_used;

    // capacity zero acts as one, above DEPTH acts as DEPTH
    always_comb begin
        if (r_cap == '0) begin
            cap_used = CAP_W'(1);
        end else if (32'(r_cap) > 32'(DEPTH)) begin
            cap_used = CAP_W'(DEPTH);
        end else begin
            cap_used = r_cap;
        end
    end

    // Accept only from idle, and only when the output register is free or draining.
    assign o_stall = (r_state != cdq_pkg::ST_IDLE) || (r_out_valid && i_stall);
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_count      = r_count;
        n_cap        = r_cap;
        n_front      = r_front;
        n_back       = r_back;
        n_rd_front   = r_rd_front;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_front  = r_out_front;
        n_out_back   = r_out_back;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_re       = 1'b0;
        mem_ra       = '0;
        emit         = 1'b0;
        status       = cdq_pkg::STS_DONE;

        case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (cdq_pkg::t_op'(i_opcode))
                        cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
                            emit = 1'b1;
                            if (CW'(r_count) >= CW'(cap_used)) begin
                                status = cdq_pkg::STS_FULL;
                            end else if (r_empty) begin
                                // first element lands in slot 0 from either end
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b0;
                                n_count = CAP_W'(1);
                                n_front = i_data_in;
                                n_back  = i_data_in;
                                mem_we  = 1'b1;
                                mem_wa  = '0;
                            end else if (i_opcode == cdq_pkg::OP_PUSH_FRONT) begin
                                n_head  = f_step_back(r_head, cap_used);
                                n_count = r_count + CAP_W'(1);
                                n_front = i_data_in;
                                mem_we  = 1'b1;
                                mem_wa  = n_head;
                            end else begin
                                n_tail  = f_step_fwd(r_tail, cap_used);
                                n_count = r_count + CAP_W'(1);
                                n_back  = i_data_in;
                                mem_we  = 1'b1;
                                mem_wa  = n_tail;
                            end
                        end
                        cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
                            if (r_empty) begin
                                emit   = 1'b1;
                                status = cdq_pkg::STS_EMPTY;
                            end else if (r_head == r_tail) begin
                                // last element out: back to the reset layout
                                emit    = 1'b1;
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b1;
                                n_count = '0;
                                n_front = '0;
                                n_back  = '0;
                            end else begin
                                // new end value comes from the slot memory next cycle
                                n_count = r_count - CAP_W'(1);
                                n_state = cdq_pkg::ST_READ;
                                mem_re  = 1'b1;
                                if (i_opcode == cdq_pkg::OP_POP_FRONT) begin
                                    n_head     = f_step_fwd(r_head, cap_used);
                                    mem_ra     = n_head;
                                    n_rd_front = 1'b1;
                                end else begin
                                    n_tail     = f_step_back(r_tail, cap_used);
                                    mem_ra     = n_tail;
                                    n_rd_front = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                // capacity change only takes while empty; indices restart at slot 0
                if (i_cfg_we && r_empty) begin
                    n_cap  = i_cfg_data;
                    n_head = '0;
                    n_tail = '0;
                end
            end
            cdq_pkg::ST_READ: begin
                // output register is free here: it was free or draining at accept
                n_state = cdq_pkg::ST_IDLE;
                emit    = 1'b1;
                if (r_rd_front) begin
                    n_front = r_rd_data;
                end else begin
                    n_back = r_rd_data;
                end
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = status;
            n_out_count  = n_count;
            n_out_front  = n_front;
            n_out_back   = n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_count     <= '0;
            r_cap       <= CAP_W'(cdq_pkg::CAP_RESET);
            r_front     <= '0;
            r_back      <= '0;
            r_rd_front  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_front     <= n_front;
            r_back      <= n_back;
            r_rd_front  <= n_rd_front;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_front  <= n_out_front;
        r_out_back   <= n_out_back;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_occupancy   = r_out_count;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CW'(cap_used))
        else $error("occupancy above usable capacity");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty == (r_count == '0))
        else $error("empty flag and occupancy disagree");

    a_empty_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("indices not at slot 0 while empty");

    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::ST_READ) |-> !r_out_valid)
        else $error("slot read finishing into an occupied output register");

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::ST_READ) |=> (r_state == cdq_pkg::ST_IDLE && r_out_valid))
        else $error("pop result not delivered after slot read");

endmodule
